@@ rtl/core/gha_pkg.sv @@
package gha_pkg;

  // fixed widths of the handle and result fields
  localparam int IN_IDX_W    = 10;
  localparam int GEN_FIELD_W = 16;
  localparam int CNT_FIELD_W = 11;

  typedef enum logic [1:0] {
    CMD_CREATE  = 2'd0,
    CMD_DESTROY = 2'd1,
    CMD_CHECK   = 2'd2
  } gha_cmd_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_INVALID = 2'd2
  } gha_status_t;

  typedef struct packed {
    logic push;
    logic pop;
  } gha_stack_op_t;

endpackage

@@ rtl/core/generational_handle_allocator.sv @@
// channel   ports                                              direction
// command   start, busy, in_command, in_handle_index,          in
//           in_handle_generation
// result    out_strobe, out_status, out_slot_index,            out
//           out_slot_generation, out_live_count
//
// one item per cycle; busy stays low
// the result strobes once the item has passed the item register, beside the
// registered read of the slot table, and then the result register
// the free stack keeps its top in a register and prefetches the next entry
// reset clears the counters and the stack depth, the rams need no clearing
// results cannot be held off, each is shown for one cycle
module generational_handle_allocator #(
  parameter int SLOT_CAPACITY = 1024,
  parameter int GEN_BITS      = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_command,
  input  logic [9:0]  in_handle_index,
  input  logic [15:0] in_handle_generation,
  output logic        out_strobe,
  output logic [1:0]  out_status,
  output logic [9:0]  out_slot_index,
  output logic [15:0] out_slot_generation,
  output logic [10:0] out_live_count
);

  localparam int IDX_W  = $clog2(SLOT_CAPACITY);
  localparam int CNT_W  = $clog2(SLOT_CAPACITY + 1);
  localparam int IIW    = gha_pkg::IN_IDX_W;
  localparam int GFW    = gha_pkg::GEN_FIELD_W;
  localparam int CFW    = gha_pkg::CNT_FIELD_W;
  localparam int CMP_W  = (CNT_W > IIW) ? CNT_W : IIW;
  localparam int GCMP_W = (GEN_BITS > GFW) ? GEN_BITS : GFW;
  localparam int OCNT_W = (CNT_W > CFW) ? CNT_W : CFW;
  localparam int STK_W  = IDX_W + GEN_BITS;
  localparam int SUM_W  = CNT_W + 1;

  logic                 accept;
  logic [CMP_W-1:0]     in_idx_ext;
  logic [IDX_W-1:0]     tbl_raddr;

  // item register
  logic                 a_valid_r;
  logic [1:0]           a_cmd_r;
  logic [IIW-1:0]       a_idx_r;
  logic [GFW-1:0]       a_gen_r;

  logic [CNT_W-1:0]     hw_r, hw_nxt;
  logic [CNT_W-1:0]     live_r, live_nxt;

  logic                 rd_active;
  logic [GEN_BITS-1:0]  rd_gen;
  logic [STK_W-1:0]     stk_top;
  logic [CNT_W-1:0]     stk_cnt;

  gha_pkg::gha_stack_op_t stk_op;
  logic [STK_W-1:0]     push_data;
  logic                 tbl_we;
  logic [IDX_W-1:0]     tbl_waddr;
  logic                 tbl_wactive;
  logic [GEN_BITS-1:0]  tbl_wgen;

  logic [CMP_W-1:0]     a_idx_ext;
  logic [IDX_W-1:0]     a_idx;
  logic                 in_range;
  logic                 gen_match;
  logic                 handle_ok;
  logic [GCMP_W-1:0]    new_gen_ext;

  gha_pkg::gha_status_t status_nxt;
  logic [IIW-1:0]       res_idx_nxt;
  logic [GFW-1:0]       res_gen_nxt;
  logic [IDX_W-1:0]     slot;
  logic [GEN_BITS-1:0]  new_gen;
  logic [CMP_W-1:0]     slot_ext;
  logic [OCNT_W-1:0]    live_ext;

  // result register
  logic                 out_strobe_r;
  logic [1:0]           out_status_r;
  logic [IIW-1:0]       out_idx_r;
  logic [GFW-1:0]       out_gen_r;
  logic [CFW-1:0]       out_live_r;

  assign busy       = 1'b0;
  assign accept     = start && !busy;
  assign in_idx_ext = CMP_W'(in_handle_index);
  assign tbl_raddr  = in_idx_ext[IDX_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else begin
      a_valid_r <= accept;
    end
    a_cmd_r <= in_command;
    a_idx_r <= in_handle_index;
    a_gen_r <= in_handle_generation;
  end

  gha_slot_table #(
    .GEN_BITS(GEN_BITS),
    .DEPTH   (SLOT_CAPACITY)
  ) u_slot_table (
    .clk      (clk),
    .rst_n    (rst_n),
    .we       (tbl_we),
    .waddr    (tbl_waddr),
    .wactive  (tbl_wactive),
    .wgen     (tbl_wgen),
    .raddr    (tbl_raddr),
    .rd_active(rd_active),
    .rd_gen   (rd_gen)
  );

  gha_free_stack #(
    .WIDTH(STK_W),
    .DEPTH(SLOT_CAPACITY)
  ) u_free_stack (
    .clk      (clk),
    .rst_n    (rst_n),
    .op       (stk_op),
    .push_data(push_data),
    .top      (stk_top),
    .count    (stk_cnt)
  );

  assign a_idx_ext = CMP_W'(a_idx_r);
  assign a_idx     = a_idx_ext[IDX_W-1:0];
  assign in_range  = a_idx_ext < CMP_W'(hw_r);
  assign gen_match = GCMP_W'(rd_gen) == GCMP_W'(a_gen_r);
  assign handle_ok = in_range && rd_active && gen_match;

  always_comb begin
    status_nxt  = gha_pkg::ST_INVALID;
    res_idx_nxt = a_idx_r;
    res_gen_nxt = a_gen_r;
    hw_nxt      = hw_r;
    live_nxt    = live_r;
    stk_op      = '0;
    // a freed slot carries the generation its next owner gets
    push_data   = {a_idx, GEN_BITS'(rd_gen + GEN_BITS'(1))};
    tbl_we      = 1'b0;
    tbl_waddr   = a_idx;
    tbl_wactive = 1'b0;
    tbl_wgen    = rd_gen;
    slot        = stk_top[STK_W-1:GEN_BITS];
    new_gen     = stk_top[GEN_BITS-1:0];
    if (a_valid_r) begin
      unique case (a_cmd_r)
        gha_pkg::CMD_CREATE: begin
          if (stk_cnt != '0 || hw_r != CNT_W'(SLOT_CAPACITY)) begin
            if (stk_cnt != '0) begin
              stk_op.pop = 1'b1;
            end else begin
              slot    = hw_r[IDX_W-1:0];
              new_gen = '0;
              hw_nxt  = hw_r + CNT_W'(1);
            end
            tbl_we      = 1'b1;
            tbl_waddr   = slot;
            tbl_wactive = 1'b1;
            tbl_wgen    = new_gen;
            live_nxt    = live_r + CNT_W'(1);
            status_nxt  = gha_pkg::ST_OK;
            res_idx_nxt = slot_ext[IIW-1:0];
            res_gen_nxt = new_gen_ext[GFW-1:0];
          end else begin
            status_nxt = gha_pkg::ST_FULL;
          end
        end
        gha_pkg::CMD_DESTROY: begin
          if (handle_ok) begin
            tbl_we      = 1'b1;
            stk_op.push = 1'b1;
            live_nxt    = live_r - CNT_W'(1);
            status_nxt  = gha_pkg::ST_OK;
          end
        end
        gha_pkg::CMD_CHECK: begin
          if (handle_ok) begin
            status_nxt = gha_pkg::ST_OK;
          end
        end
        default: begin
          status_nxt = gha_pkg::ST_INVALID;
        end
      endcase
    end
  end

  assign slot_ext    = CMP_W'(slot);
  assign new_gen_ext = GCMP_W'(new_gen);
  assign live_ext    = OCNT_W'(live_nxt);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hw_r         <= '0;
      live_r       <= '0;
      out_strobe_r <= 1'b0;
    end else begin
      hw_r         <= hw_nxt;
      live_r       <= live_nxt;
      out_strobe_r <= a_valid_r;
    end
    out_status_r <= status_nxt;
    out_idx_r    <= res_idx_nxt;
    out_gen_r    <= res_gen_nxt;
    out_live_r   <= live_ext[CFW-1:0];
  end

  assign out_strobe          = out_strobe_r;
  assign out_status          = out_status_r;
  assign out_slot_index      = out_idx_r;
  assign out_slot_generation = out_gen_r;
  assign out_live_count      = out_live_r;

  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    a_valid_r |=> out_strobe_r)
    else $error("taken item produced no result");

  a_no_phantom_result: assert property (@(posedge clk) disable iff (!rst_n)
    !a_valid_r |=> !out_strobe_r)
    else $error("result without an item");

  a_slot_accounting: assert property (@(posedge clk) disable iff (!rst_n)
    SUM_W'(stk_cnt) + SUM_W'(live_r) == SUM_W'(hw_r))
    else $error("free plus live slots differ from slots ever used");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    stk_op.pop |-> stk_cnt != '0)
    else $error("pop from empty free stack");

endmodule

@@ rtl/core/gha_ram.sv @@
module gha_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rd_data_r <= mem_r[raddr];
  end

  assign rd_data = rd_data_r;

endmodule

@@ rtl/core/gha_free_stack.sv @@
module gha_free_stack #(
  parameter int WIDTH = 26,
  parameter int DEPTH = 1024
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  gha_pkg::gha_stack_op_t     op,
  input  logic [WIDTH-1:0]           push_data,
  output logic [WIDTH-1:0]           top,
  output logic [$clog2(DEPTH+1)-1:0] count
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  // top entry lives in a register, the rest in the ram
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic [WIDTH-1:0] top_r, top_nxt;
  logic             mem_we;
  logic [CW-1:0]    waddr_full, raddr_full;
  logic [AW-1:0]    waddr, raddr;
  logic [WIDTH-1:0] rd_data;
  logic             byp_r;
  logic [WIDTH-1:0] byp_data_r;
  logic [WIDTH-1:0] mem_top;

  assign mem_top = byp_r ? byp_data_r : rd_data;

  always_comb begin
    cnt_nxt = cnt_r;
    top_nxt = top_r;
    mem_we  = 1'b0;
    if (op.push) begin
      cnt_nxt = cnt_r + CW'(1);
      top_nxt = push_data;
      mem_we  = (cnt_r != '0);
    end else if (op.pop) begin
      cnt_nxt = cnt_r - CW'(1);
      top_nxt = mem_top;
    end
  end

  // ram holds count-1 entries, keep its top entry prefetched
  assign waddr_full = cnt_r - CW'(1);
  assign raddr_full = cnt_nxt - CW'(2);
  assign waddr      = waddr_full[AW-1:0];
  assign raddr      = raddr_full[AW-1:0];

  gha_ram #(
    .WIDTH(WIDTH),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk    (clk),
    .we     (mem_we),
    .waddr  (waddr),
    .wdata  (top_r),
    .raddr  (raddr),
    .rd_data(rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      byp_r <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      byp_r <= mem_we && (waddr == raddr);
    end
    top_r      <= top_nxt;
    byp_data_r <= top_r;
  end

  assign top   = top_r;
  assign count = cnt_r;

endmodule

@@ rtl/core/gha_slot_table.sv @@
module gha_slot_table #(
  parameter int GEN_BITS = 16,
  parameter int DEPTH    = 1024
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic                     wactive,
  input  logic [GEN_BITS-1:0]      wgen,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic                     rd_active,
  output logic [GEN_BITS-1:0]      rd_gen
);

  localparam int EW = GEN_BITS + 1;

  // entries below the high water mark are always written before their data is used
  logic [EW-1:0] wdata, rd_data, entry;
  logic          byp_r;
  logic [EW-1:0] byp_data_r;

  assign wdata = {wactive, wgen};

  gha_ram #(
    .WIDTH(EW),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk    (clk),
    .we     (we),
    .waddr  (waddr),
    .wdata  (wdata),
    .raddr  (raddr),
    .rd_data(rd_data)
  );

  // write landing on the address being read this edge
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byp_r <= 1'b0;
    end else begin
      byp_r <= we && (waddr == raddr);
    end
    byp_data_r <= wdata;
  end

  assign entry     = byp_r ? byp_data_r : rd_data;
  assign rd_active = entry[EW-1];
  assign rd_gen    = entry[GEN_BITS-1:0];

endmodule
